// ===== design/gpio_port_with_pin_interrupts_assert.svh =====
// assertion macros for the gpio port
// used by gpio_port_with_pin_interrupts; expects clk and rst_n in scope
`ifndef GPIO_PORT_WITH_PIN_INTERRUPTS_ASSERT_SVH
`define GPIO_PORT_WITH_PIN_INTERRUPTS_ASSERT_SVH

`ifndef SYNTHESIS
`define GPIO_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define GPIO_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define GPIO_ASSERT(lbl, prop, msg)
`define GPIO_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ===== design/gpio_pkg.sv =====
// shared types and codes for the gpio port
// no dependencies
package gpio_pkg;

  typedef enum logic [1:0] {
    REQ_TICK  = 2'd0,
    REQ_READ  = 2'd1,
    REQ_WRITE = 2'd2,
    REQ_IDLE  = 2'd3
  } req_kind_t;

  localparam logic [3:0] REG_IN     = 4'd0;
  localparam logic [3:0] REG_OE     = 4'd1;
  localparam logic [3:0] REG_OUT    = 4'd2;
  localparam logic [3:0] REG_RISEIE = 4'd3;
  localparam logic [3:0] REG_RISEIP = 4'd4;
  localparam logic [3:0] REG_FALLIE = 4'd5;
  localparam logic [3:0] REG_FALLIP = 4'd6;
  localparam logic [3:0] REG_HIGHIE = 4'd7;
  localparam logic [3:0] REG_HIGHIP = 4'd8;
  localparam logic [3:0] REG_LOWIE  = 4'd9;
  localparam logic [3:0] REG_LOWIP  = 4'd10;

  localparam int KIND_RISE = 0;
  localparam int KIND_FALL = 1;
  localparam int KIND_HIGH = 2;
  localparam int KIND_LOW  = 3;
  localparam int KIND_NUM  = 4;

  localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;

  typedef struct packed {
    req_kind_t   kind;
    logic [3:0]  reg_index;
    logic [31:0] write_data;
    logic [31:0] pin_levels;
  } req_t;

  typedef struct packed {
    logic [31:0] pin_interrupts;
    logic [31:0] pin_drive_enable;
    logic [31:0] pin_drive;
    logic [31:0] read_data;
  } view_t;

endpackage

// ===== design/gpio_regfile.sv =====
// gpio register file: pin sampling, pending bits, register access
// depends on gpio_pkg
module gpio_regfile #(
  parameter logic [31:0] PinMask = 32'hFFFF_FFFF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           req_en,
  input  gpio_pkg::req_t req,
  output gpio_pkg::view_t view
);

  logic [31:0] in_lvl_r, in_lvl_nxt;
  logic [31:0] oe_r, oe_nxt;
  logic [31:0] out_r, out_nxt;
  logic [31:0] ie_r [gpio_pkg::KIND_NUM];
  logic [31:0] ie_nxt [gpio_pkg::KIND_NUM];
  logic [31:0] ip_r [gpio_pkg::KIND_NUM];
  logic [31:0] ip_nxt [gpio_pkg::KIND_NUM];
  logic [31:0] rdata;
  logic [31:0] smp;
  logic [31:0] wd;
  logic [31:0] irq;

  assign smp = req.pin_levels & PinMask;
  assign wd  = req.write_data & PinMask;

  always_comb begin
    in_lvl_nxt = in_lvl_r;
    oe_nxt     = oe_r;
    out_nxt    = out_r;
    ie_nxt     = ie_r;
    ip_nxt     = ip_r;
    rdata      = '0;
    unique case (req.kind)
      gpio_pkg::REQ_TICK: begin
        ip_nxt[gpio_pkg::KIND_RISE] = ip_r[gpio_pkg::KIND_RISE] | (smp & ~in_lvl_r);
        ip_nxt[gpio_pkg::KIND_FALL] = ip_r[gpio_pkg::KIND_FALL] | (~smp & in_lvl_r & PinMask);
        ip_nxt[gpio_pkg::KIND_HIGH] = ip_r[gpio_pkg::KIND_HIGH] | smp;
        ip_nxt[gpio_pkg::KIND_LOW]  = ip_r[gpio_pkg::KIND_LOW] | (~smp & PinMask);
        in_lvl_nxt = smp;
      end
      gpio_pkg::REQ_READ: begin
        unique case (req.reg_index)
          gpio_pkg::REG_IN:     rdata = in_lvl_r;
          gpio_pkg::REG_OE:     rdata = oe_r;
          gpio_pkg::REG_OUT:    rdata = out_r;
          gpio_pkg::REG_RISEIE: rdata = ie_r[gpio_pkg::KIND_RISE];
          gpio_pkg::REG_RISEIP: rdata = ip_r[gpio_pkg::KIND_RISE];
          gpio_pkg::REG_FALLIE: rdata = ie_r[gpio_pkg::KIND_FALL];
          gpio_pkg::REG_FALLIP: rdata = ip_r[gpio_pkg::KIND_FALL];
          gpio_pkg::REG_HIGHIE: rdata = ie_r[gpio_pkg::KIND_HIGH];
          gpio_pkg::REG_HIGHIP: rdata = ip_r[gpio_pkg::KIND_HIGH];
          gpio_pkg::REG_LOWIE:  rdata = ie_r[gpio_pkg::KIND_LOW];
          gpio_pkg::REG_LOWIP:  rdata = ip_r[gpio_pkg::KIND_LOW];
          default:              rdata = '0;
        endcase
      end
      gpio_pkg::REQ_WRITE: begin
        // pending registers are write-one-to-clear, input value is read only
        unique case (req.reg_index)
          gpio_pkg::REG_OE:     oe_nxt = wd;
          gpio_pkg::REG_OUT:    out_nxt = wd;
          gpio_pkg::REG_RISEIE: ie_nxt[gpio_pkg::KIND_RISE] = wd;
          gpio_pkg::REG_RISEIP: ip_nxt[gpio_pkg::KIND_RISE] = ip_r[gpio_pkg::KIND_RISE] & ~wd;
          gpio_pkg::REG_FALLIE: ie_nxt[gpio_pkg::KIND_FALL] = wd;
          gpio_pkg::REG_FALLIP: ip_nxt[gpio_pkg::KIND_FALL] = ip_r[gpio_pkg::KIND_FALL] & ~wd;
          gpio_pkg::REG_HIGHIE: ie_nxt[gpio_pkg::KIND_HIGH] = wd;
          gpio_pkg::REG_HIGHIP: ip_nxt[gpio_pkg::KIND_HIGH] = ip_r[gpio_pkg::KIND_HIGH] & ~wd;
          gpio_pkg::REG_LOWIE:  ie_nxt[gpio_pkg::KIND_LOW] = wd;
          gpio_pkg::REG_LOWIP:  ip_nxt[gpio_pkg::KIND_LOW] = ip_r[gpio_pkg::KIND_LOW] & ~wd;
          default: begin
          end
        endcase
      end
      gpio_pkg::REQ_IDLE: begin
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    irq = '0;
    for (int k = 0; k < gpio_pkg::KIND_NUM; k++) begin
      irq = irq | (ip_nxt[k] & ie_nxt[k]);
    end
  end

  // result reflects the state after the transfer is applied
  assign view.read_data        = rdata;
  assign view.pin_drive        = out_nxt & PinMask;
  assign view.pin_drive_enable = oe_nxt & PinMask;
  assign view.pin_interrupts   = irq & PinMask;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_lvl_r <= '0;
      oe_r     <= '0;
      out_r    <= '0;
      for (int k = 0; k < gpio_pkg::KIND_NUM; k++) begin
        ie_r[k] <= '0;
        ip_r[k] <= '0;
      end
    end else if (req_en) begin
      in_lvl_r <= in_lvl_nxt;
      oe_r     <= oe_nxt;
      out_r    <= out_nxt;
      ie_r     <= ie_nxt;
      ip_r     <= ip_nxt;
    end
  end

endmodule

// ===== design/gpio_port_with_pin_interrupts.sv =====
// gpio port top level: stream handshake and result register
// depends on gpio_pkg, gpio_regfile and gpio_port_with_pin_interrupts_assert.svh
// the result is registered: valid in the cycle after the input transfer
// throughput: one item per cycle while out_tready holds, set by the single result register
// a new item is taken while a result waits as long as that result is taken the same cycle
// reset: synchronous active-low rst_n clears the register file and the result valid, not the result data
module gpio_port_with_pin_interrupts #(
  parameter int PIN_COUNT = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [71:0]  in_tdata,   // reg_index[3:0], write_data[35:4], pin_levels[67:36], zero pad
  input  logic [1:0]   in_tuser,   // req_type[1:0]
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [127:0] out_tdata   // read_data, pin_drive, pin_drive_enable, pin_interrupts
);

  localparam logic [31:0] PinMask = gpio_pkg::ALL_ONES >> (32 - PIN_COUNT);

  gpio_pkg::req_t  req;
  gpio_pkg::view_t view;
  logic            in_xfer;
  logic            out_vld_r, out_vld_nxt;
  gpio_pkg::view_t res_r;
  logic            tick_xfer;
  logic [95:0]     unused_bits;

  assign in_tready = !out_vld_r || out_tready;
  assign in_xfer   = in_tvalid && in_tready;

  assign req.kind       = gpio_pkg::req_kind_t'(in_tuser);
  assign req.reg_index  = in_tdata[3:0];
  assign req.write_data = in_tdata[35:4];
  assign req.pin_levels = in_tdata[67:36];

  gpio_regfile #(
    .PinMask(PinMask)
  ) u_regfile (
    .clk   (clk),
    .rst_n (rst_n),
    .req_en(in_xfer),
    .req   (req),
    .view  (view)
  );

  always_comb begin
    out_vld_nxt = out_vld_r;
    if (in_xfer) begin
      out_vld_nxt = 1'b1;
    end else if (out_tready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      res_r <= view;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = res_r;

  assign tick_xfer   = in_xfer && (req.kind == gpio_pkg::REQ_TICK);
  assign unused_bits = out_tdata[127:32] & ~{PinMask, PinMask, PinMask};

`include "gpio_port_with_pin_interrupts_assert.svh"

  `GPIO_ASSERT(a_xfer_gives_result, in_xfer |=> out_tvalid, "accepted item lost")
  `GPIO_ASSERT(a_tick_reads_zero, tick_xfer |=> out_tdata[31:0] == 32'd0, "tick returned read data")
  `GPIO_ASSERT(a_unused_pins_quiet, out_tvalid |-> unused_bits == 96'd0, "unused pin driven")
  `GPIO_ASSERT_ALWAYS(a_reset_clears_valid, !rst_n |=> !out_tvalid, "result valid after reset")

endmodule
